FILE: sv/mkd_pkg.sv
// Shared types, constants and Morse table for the Morse key decoder.
package mkd_pkg;

  localparam int MAX_SYMBOLS_DEF = 5;

  localparam int MS_W      = 13;
  localparam int TICKS_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int LEN_W     = 3;
  localparam int TBL_BITS_W = 5;
  localparam int ASCII_W   = 7;

  // ms = floor(ticks * 8 / 125) = (ticks * MS_RECIP) >> MS_SHIFT, exact for 16-bit ticks
  localparam int MS_RECIP_W = 20;
  localparam int MS_SHIFT   = 23;
  localparam logic [MS_RECIP_W-1:0] MS_RECIP = 20'd536871;

  localparam logic [MS_W-1:0]    DOT_MIN_RST   = 13'd30;
  localparam logic [MS_W-1:0]    SPLIT_RST     = 13'd200;
  localparam logic [MS_W-1:0]    DASH_MAX_RST  = 13'd400;
  localparam logic [TICKS_W-1:0] GAP_TICKS_RST = 16'd15625;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOT_MIN   = 2'd0,
    REG_SPLIT     = 2'd1,
    REG_DASH_MAX  = 2'd2,
    REG_GAP_TICKS = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SYM_NONE = 2'd0,
    SYM_DOT  = 2'd1,
    SYM_DASH = 2'd2
  } sym_kind_t;

  typedef enum logic {
    MODE_PRESS = 1'b0,
    MODE_GAP   = 1'b1
  } ev_mode_t;

  typedef struct packed {
    logic [MS_W-1:0] dot_min;
    logic [MS_W-1:0] split;
    logic [MS_W-1:0] dash_max;
  } press_bounds_t;

  typedef struct packed {
    logic               hit;
    logic [ASCII_W-1:0] code;
  } char_hit_t;

  typedef struct packed {
    logic [LEN_W-1:0]      len;
    logic [TBL_BITS_W-1:0] bits;
    logic [ASCII_W-1:0]    ascii;
  } morse_entry_t;

  localparam int MORSE_ENTRIES = 36;

  // first symbol in the MSB of the used length, dot 0, dash 1
  localparam morse_entry_t MORSE_TABLE [MORSE_ENTRIES] = '{
    '{3'd2, 5'h01, 7'h41}, '{3'd4, 5'h08, 7'h42}, '{3'd4, 5'h0A, 7'h43},
    '{3'd3, 5'h04, 7'h44}, '{3'd1, 5'h00, 7'h45}, '{3'd4, 5'h02, 7'h46},
    '{3'd3, 5'h06, 7'h47}, '{3'd4, 5'h00, 7'h48}, '{3'd2, 5'h00, 7'h49},
    '{3'd4, 5'h07, 7'h4A}, '{3'd3, 5'h05, 7'h4B}, '{3'd4, 5'h04, 7'h4C},
    '{3'd2, 5'h03, 7'h4D}, '{3'd2, 5'h02, 7'h4E}, '{3'd3, 5'h07, 7'h4F},
    '{3'd4, 5'h06, 7'h50}, '{3'd4, 5'h0D, 7'h51}, '{3'd3, 5'h02, 7'h52},
    '{3'd3, 5'h00, 7'h53}, '{3'd1, 5'h01, 7'h54}, '{3'd3, 5'h01, 7'h55},
    '{3'd4, 5'h01, 7'h56}, '{3'd3, 5'h03, 7'h57}, '{3'd4, 5'h09, 7'h58},
    '{3'd4, 5'h0B, 7'h59}, '{3'd4, 5'h0C, 7'h5A},
    '{3'd5, 5'h0F, 7'h31}, '{3'd5, 5'h07, 7'h32}, '{3'd5, 5'h03, 7'h33},
    '{3'd5, 5'h01, 7'h34}, '{3'd5, 5'h00, 7'h35}, '{3'd5, 5'h10, 7'h36},
    '{3'd5, 5'h18, 7'h37}, '{3'd5, 5'h1C, 7'h38}, '{3'd5, 5'h1E, 7'h39},
    '{3'd5, 5'h1F, 7'h30}
  };

endpackage

FILE: sv/morse_key_decoder.sv
// Morse key decoder top level: config registers, pattern state and transfer pipeline.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | in_mode, in_duration_ticks
//  out     | output    | out_valid/out_stall | symbol_kind, char_valid, char_code,
//          |           |                     | unknown_pattern, overflowed
//  cfg     | input     | cfg_we              | cfg_index, cfg_wdata
//
// One item per cycle sustained while out_stall is low. An input transfer goes
// into an input register, then through the ms multiply, classifier and
// table compare into the result register.
// Reset (synchronous) clears the pattern, arm state and both valids and loads the config defaults.
// A stalled result holds; one more item may sit in the input register.
module morse_key_decoder #(
  parameter int MAX_SYMBOLS = mkd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_mode,
  input  logic [mkd_pkg::TICKS_W-1:0]    in_duration_ticks,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_symbol_kind,
  output logic                           out_char_valid,
  output logic [mkd_pkg::ASCII_W-1:0]    out_char_code,
  output logic                           out_unknown_pattern,
  output logic                           out_overflowed,
  input  logic                           cfg_we,
  input  logic [mkd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mkd_pkg::CFG_W-1:0]      cfg_wdata
);
  import mkd_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SYMBOLS);

  press_bounds_t        bounds_r;
  logic [TICKS_W-1:0]   gap_ticks_r;

  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_mode_r;
  logic [TICKS_W-1:0]   s1_ticks_r;

  logic [MAX_SYMBOLS-1:0] pat_bits_r, pat_bits_nxt;
  logic [LEN_W-1:0]     pat_len_r, pat_len_nxt;
  logic                 gap_done_r, gap_done_nxt;
  logic                 ovf_mark_r, ovf_mark_nxt;

  logic                 out_valid_r, out_valid_nxt;
  sym_kind_t            kind_r, kind_nxt;
  logic                 cvalid_r, cvalid_nxt;
  logic [ASCII_W-1:0]   code_r, code_nxt;
  logic                 unknown_r, unknown_nxt;
  logic                 ovf_r, ovf_nxt;

  logic                 in_xfer;
  logic                 advance;
  sym_kind_t            sym;
  char_hit_t            hit;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  mkd_sym_class u_class (
    .ticks  (s1_ticks_r),
    .bounds (bounds_r),
    .kind   (sym)
  );

  mkd_char_lookup #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_lookup (
    .pat_bits (pat_bits_r),
    .pat_len  (pat_len_r),
    .result   (hit)
  );

  always_comb begin
    pat_bits_nxt = pat_bits_r;
    pat_len_nxt  = pat_len_r;
    gap_done_nxt = gap_done_r;
    ovf_mark_nxt = ovf_mark_r;
    kind_nxt     = SYM_NONE;
    cvalid_nxt   = 1'b0;
    code_nxt     = '0;
    unknown_nxt  = 1'b0;
    ovf_nxt      = 1'b0;
    if (ev_mode_t'(s1_mode_r) == MODE_PRESS) begin
      if (sym != SYM_NONE) begin
        gap_done_nxt = 1'b0;
        if (pat_len_r < MAX_LEN) begin
          pat_bits_nxt = {pat_bits_r[MAX_SYMBOLS-2:0], sym == SYM_DASH};
          pat_len_nxt  = pat_len_r + 1'b1;
          kind_nxt     = sym;
        end else begin
          ovf_mark_nxt = 1'b1;
          ovf_nxt      = 1'b1;
        end
      end
    end else if (s1_ticks_r > gap_ticks_r && !gap_done_r) begin
      if (ovf_mark_r) begin
        unknown_nxt = 1'b1;
        ovf_nxt     = 1'b1;
      end else if (pat_len_r != '0) begin
        cvalid_nxt  = hit.hit;
        code_nxt    = hit.code;
        unknown_nxt = !hit.hit;
      end
      pat_bits_nxt = '0;
      pat_len_nxt  = '0;
      ovf_mark_nxt = 1'b0;
      gap_done_nxt = 1'b1;
    end
  end

  always_comb begin
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = advance || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r.dot_min  <= DOT_MIN_RST;
      bounds_r.split    <= SPLIT_RST;
      bounds_r.dash_max <= DASH_MAX_RST;
      gap_ticks_r       <= GAP_TICKS_RST;
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      pat_bits_r        <= '0;
      pat_len_r         <= '0;
      gap_done_r        <= 1'b0;
      ovf_mark_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_DOT_MIN:   bounds_r.dot_min  <= cfg_wdata[MS_W-1:0];
          REG_SPLIT:     bounds_r.split    <= cfg_wdata[MS_W-1:0];
          REG_DASH_MAX:  bounds_r.dash_max <= cfg_wdata[MS_W-1:0];
          REG_GAP_TICKS: gap_ticks_r       <= cfg_wdata[TICKS_W-1:0];
          default: ;
        endcase
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        pat_bits_r <= pat_bits_nxt;
        pat_len_r  <= pat_len_nxt;
        gap_done_r <= gap_done_nxt;
        ovf_mark_r <= ovf_mark_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_mode_r  <= in_mode;
      s1_ticks_r <= in_duration_ticks;
    end
    if (advance) begin
      kind_r    <= kind_nxt;
      cvalid_r  <= cvalid_nxt;
      code_r    <= code_nxt;
      unknown_r <= unknown_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_symbol_kind     = kind_r;
  assign out_char_valid      = cvalid_r;
  assign out_char_code       = code_r;
  assign out_unknown_pattern = unknown_r;
  assign out_overflowed      = ovf_r;

endmodule

FILE: sv/mkd_sym_class.sv
// Press length to milliseconds and dot/dash classification.
module mkd_sym_class (
  input  logic [mkd_pkg::TICKS_W-1:0] ticks,
  input  mkd_pkg::press_bounds_t      bounds,
  output mkd_pkg::sym_kind_t          kind
);
  import mkd_pkg::*;

  localparam int PROD_W = TICKS_W + MS_RECIP_W;

  logic [PROD_W-1:0] prod;
  logic [MS_W-1:0]   ms;

  assign prod = PROD_W'(ticks) * PROD_W'(MS_RECIP);
  assign ms   = prod[MS_SHIFT +: MS_W];

  always_comb begin
    if (ms > bounds.dot_min && ms < bounds.split) begin
      kind = SYM_DOT;
    end else if (ms > bounds.split && ms < bounds.dash_max) begin
      kind = SYM_DASH;
    end else begin
      kind = SYM_NONE;
    end
  end

endmodule

FILE: sv/mkd_char_lookup.sv
// Pattern to ASCII lookup over the letter and digit table.
module mkd_char_lookup #(
  parameter int MAX_SYMBOLS = mkd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic [MAX_SYMBOLS-1:0]    pat_bits,
  input  logic [mkd_pkg::LEN_W-1:0] pat_len,
  output mkd_pkg::char_hit_t        result
);
  import mkd_pkg::*;

  localparam int CMP_W = (MAX_SYMBOLS > TBL_BITS_W) ? MAX_SYMBOLS : TBL_BITS_W;

  always_comb begin
    logic match;
    result = '0;
    for (int k = 0; k < MORSE_ENTRIES; k++) begin
      match = (MORSE_TABLE[k].len == pat_len) &&
              (CMP_W'(MORSE_TABLE[k].bits) == CMP_W'(pat_bits));
      result.hit  = result.hit | match;
      result.code = result.code | (match ? MORSE_TABLE[k].ascii : '0);
    end
  end

endmodule

FILE: sv/mkd_checker.sv
// Port-level checks for the Morse key decoder, bound to the top level.
module mkd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  out_symbol_kind,
  input logic                        out_char_valid,
  input logic [mkd_pkg::ASCII_W-1:0] out_char_code,
  input logic                        out_unknown_pattern,
  input logic                        out_overflowed
);
  import mkd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_symbol_kind) &&
      $stable(out_char_valid) && $stable(out_char_code) &&
      $stable(out_unknown_pattern) && $stable(out_overflowed))
    else $error("stalled result changed");

  a_char_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_valid |-> out_symbol_kind == SYM_NONE &&
      !out_unknown_pattern && !out_overflowed && out_char_code != '0)
    else $error("character result mixed with other outcomes");

  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_char_valid |-> out_char_code == '0)
    else $error("char code set without a character");

  a_sym_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_symbol_kind != SYM_NONE |-> !out_overflowed &&
      !out_unknown_pattern)
    else $error("appended symbol flagged as dropped or unknown");

endmodule

bind morse_key_decoder mkd_checker u_mkd_checker (.*);

FILE: tb/sv/morse_decode_checker.sv
`timescale 1ns / 100ps
// Watches the Morse key decoder's channels, predicts each result and compares it.
module morse_decode_checker #(
  parameter int MAX_SYMBOLS = mkd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_mode,
  input  logic [mkd_pkg::TICKS_W-1:0]   in_duration_ticks,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [1:0]                    out_symbol_kind,
  input  logic                          out_char_valid,
  input  logic [mkd_pkg::ASCII_W-1:0]   out_char_code,
  input  logic                          out_unknown_pattern,
  input  logic                          out_overflowed,
  input  logic                          cfg_we,
  input  logic [mkd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mkd_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            fail_count,
  output int                            pending_results,
  output int                            checked_count,
  output int                            char_count,
  output int                            unknown_count
);
  import mkd_pkg::*;

  localparam int PRINT_CAP = 50;

  // leading 1 marks the length; dot 0, dash 1, first symbol highest
  localparam logic [7:0] MORSE_KEYS [36] = '{
    8'h05, 8'h18, 8'h1A, 8'h0C, 8'h02, 8'h12, 8'h0E, 8'h10, 8'h04,
    8'h17, 8'h0D, 8'h14, 8'h07, 8'h06, 8'h0F, 8'h16, 8'h1D, 8'h0A,
    8'h08, 8'h03, 8'h09, 8'h11, 8'h0B, 8'h19, 8'h1B, 8'h1C,
    8'h2F, 8'h27, 8'h23, 8'h21, 8'h20, 8'h30, 8'h38, 8'h3C, 8'h3E, 8'h3F
  };

  typedef struct packed {
    sym_kind_t          kind;
    logic               char_valid;
    logic [ASCII_W-1:0] char_code;
    logic               unknown;
    logic               overflow;
  } decode_result_t;

  logic [MS_W-1:0]        dot_min, split, dash_max;
  logic [TICKS_W-1:0]     gap_thr;
  logic [MAX_SYMBOLS-1:0] pattern;
  int unsigned            held;
  logic                   disarmed, dropped;
  decode_result_t         expected_decodes [$];

  initial begin
    fail_count      = 0;
    pending_results = 0;
    checked_count   = 0;
    char_count      = 0;
    unknown_count   = 0;
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (fail_count < PRINT_CAP)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic logic [ASCII_W-1:0] morse_char(int unsigned len,
                                                    logic [MAX_SYMBOLS-1:0] bits);
    logic [7:0] key;
    key = (8'd1 << len) | 8'(bits);
    for (int i = 0; i < 36; i++) begin
      if (MORSE_KEYS[i] == key) begin
        if (i < 26) return 7'(8'("A") + i);
        if (i < 35) return 7'(8'("1") + i - 26);
        return 7'("0");
      end
    end
    return '0;
  endfunction

  function automatic decode_result_t decode_event(ev_mode_t mode,
                                                  logic [TICKS_W-1:0] ticks);
    decode_result_t r;
    int unsigned    ms;
    sym_kind_t      sym;
    r = '0;
    if (mode == MODE_PRESS) begin
      ms  = (32'(ticks) * 32'd64) / 32'd1000;
      sym = SYM_NONE;
      if (ms > dot_min && ms < split) sym = SYM_DOT;
      else if (ms > split && ms < dash_max) sym = SYM_DASH;
      if (sym != SYM_NONE) begin
        disarmed = 1'b0;
        if (held < MAX_SYMBOLS) begin
          pattern = {pattern[MAX_SYMBOLS-2:0], sym == SYM_DASH};
          held++;
          r.kind = sym;
        end else begin
          dropped    = 1'b1;
          r.overflow = 1'b1;
        end
      end
    end else if (ticks > gap_thr && !disarmed) begin
      if (dropped) begin
        r.unknown  = 1'b1;
        r.overflow = 1'b1;
      end else if (held != 0) begin
        r.char_code = morse_char(held, pattern);
        if (r.char_code != '0) r.char_valid = 1'b1;
        else r.unknown = 1'b1;
      end
      pattern  = '0;
      held     = 0;
      dropped  = 1'b0;
      disarmed = 1'b1;
    end
    return r;
  endfunction

  // inputs move only at rising edges, so the falling edge sees what the next one takes
  always @(negedge clk) begin
    decode_result_t want;
    if (!rst_n) begin
      dot_min  = 13'd30;
      split    = 13'd200;
      dash_max = 13'd400;
      gap_thr  = 16'd15625;
      pattern  = '0;
      held     = 0;
      disarmed = 1'b0;
      dropped  = 1'b0;
      expected_decodes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_decodes.size() == 0) begin
          report_mismatch("result with none expected", out_char_code, 0);
        end else begin
          want = expected_decodes.pop_front();
          checked_count++;
          if (want.char_valid) char_count++;
          if (want.unknown) unknown_count++;
          if (out_symbol_kind !== want.kind)
            report_mismatch("symbol_kind", out_symbol_kind, want.kind);
          if (out_char_valid !== want.char_valid)
            report_mismatch("char_valid", out_char_valid, want.char_valid);
          if (out_char_code !== want.char_code)
            report_mismatch("char_code", out_char_code, want.char_code);
          if (out_unknown_pattern !== want.unknown)
            report_mismatch("unknown_pattern", out_unknown_pattern, want.unknown);
          if (out_overflowed !== want.overflow)
            report_mismatch("overflowed", out_overflowed, want.overflow);
        end
      end
      if (in_valid && !in_stall)
        expected_decodes.push_back(decode_event(ev_mode_t'(in_mode), in_duration_ticks));
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_DOT_MIN:   dot_min  = cfg_wdata[MS_W-1:0];
          REG_SPLIT:     split    = cfg_wdata[MS_W-1:0];
          REG_DASH_MAX:  dash_max = cfg_wdata[MS_W-1:0];
          REG_GAP_TICKS: gap_thr  = cfg_wdata[TICKS_W-1:0];
          default: ;
        endcase
      end
    end
    pending_results = expected_decodes.size();
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Stimulus, flow control and verdict for the Morse key decoder testbench.
module testbench;
  import mkd_pkg::*;

  localparam int PHASES      = 8;
  localparam int HOLD_CYCLES = 60;
  localparam int MS_CEIL     = 4194;

  logic                 clk;
  logic                 rst_n             = 1'b0;
  logic                 in_valid          = 1'b0;
  logic                 in_stall;
  logic                 in_mode           = 1'b0;
  logic [TICKS_W-1:0]   in_duration_ticks = '0;
  logic                 out_valid;
  logic                 out_stall         = 1'b0;
  logic [1:0]           out_symbol_kind;
  logic                 out_char_valid;
  logic [ASCII_W-1:0]   out_char_code;
  logic                 out_unknown_pattern;
  logic                 out_overflowed;
  logic                 cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index         = '0;
  logic [CFG_W-1:0]     cfg_wdata         = '0;

  int fail_count, pending_results, checked_count, char_count, unknown_count;

  int unsigned cur_dot_min  = DOT_MIN_RST;
  int unsigned cur_split    = SPLIT_RST;
  int unsigned cur_dash_max = DASH_MAX_RST;
  int unsigned cur_gap      = GAP_TICKS_RST;
  int          sent         = 0;
  bit          tx_idle      = 1'b1;
  bit          rx_idle      = 1'b1;
  bit          rx_hold      = 1'b0;
  bit          hold_req     = 1'b0;

  morse_key_decoder DUT (.*);

  morse_decode_checker decode_check (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d results outstanding", pending_results);
    $display("== FAIL ==");
    $finish;
  end

  // receiver: random stall per result, plus long holds on request
  initial begin
    int unsigned n;
    bit          took;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_idle = !rx_idle;
      n = rx_idle ? $urandom_range(0, 8) : 0;
      if (rx_hold || n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        took = out_valid && !out_stall;
        @(posedge clk);
      end while (!took);
    end
  end

  initial begin
    forever begin
      wait (hold_req);
      @(negedge clk);
      rx_hold = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      rx_hold  = 1'b0;
      hold_req = 1'b0;
    end
  end

  function automatic int unsigned ms_ticks(int unsigned ms);
    return (ms * 1000 + 63) / 64;
  endfunction

  // ticks inside the open window of the current bounds, edges favoured
  function automatic logic [TICKS_W-1:0] press_ticks(sym_kind_t sym);
    int unsigned lo, hi, t_lo, t_hi;
    lo = (sym == SYM_DOT) ? cur_dot_min : cur_split;
    hi = (sym == SYM_DOT) ? cur_split : cur_dash_max;
    if (hi > MS_CEIL + 1) hi = MS_CEIL + 1;
    if (lo + 2 > hi) return 16'($urandom);
    t_lo = ms_ticks(lo + 1);
    t_hi = ms_ticks(hi) - 1;
    if (t_hi > 65535) t_hi = 65535;
    case ($urandom_range(0, 7))
      0:       return 16'(t_lo);
      1:       return 16'(t_hi);
      default: return 16'($urandom_range(t_lo, t_hi));
    endcase
  endfunction

  function automatic logic [TICKS_W-1:0] long_gap();
    if (cur_gap >= 65535) return 16'($urandom);
    if ($urandom_range(0, 3) == 0) return 16'(cur_gap + 1);
    return 16'($urandom_range(cur_gap + 1, 65535));
  endfunction

  task automatic send_item(ev_mode_t mode, logic [TICKS_W-1:0] ticks);
    int unsigned pause;
    bit          stalled;
    if ($urandom_range(0, 63) == 0) tx_idle = !tx_idle;
    pause = (tx_idle && !rx_hold) ? $urandom_range(0, 8) : 0;
    if (pause != 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_mode           <= mode;
    in_duration_ticks <= ticks;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    sent++;
  endtask

  // mostly whole characters with random content, some noise and broken ones
  task automatic send_word();
    int unsigned shape, len, r;
    shape = $urandom_range(0, 9);
    if (shape <= 6) begin
      r = $urandom_range(0, 19);
      if (r == 0) len = 0;
      else if (r <= 14) len = $urandom_range(1, 4);
      else if (r <= 17) len = 5;
      else len = $urandom_range(6, 7);
      repeat (len) begin
        send_item(MODE_PRESS, press_ticks($urandom_range(0, 1) ? SYM_DASH : SYM_DOT));
        if ($urandom_range(0, 15) == 0) send_item(MODE_PRESS, 16'($urandom));
        if ($urandom_range(0, 15) == 0)
          send_item(MODE_GAP, 16'($urandom_range(0, cur_gap)));
      end
      send_item(MODE_GAP, long_gap());
    end else if (shape == 7) begin
      repeat ($urandom_range(1, 4))
        send_item(ev_mode_t'($urandom_range(0, 1)), 16'($urandom));
    end else if (shape == 8) begin
      repeat ($urandom_range(1, 3))
        send_item(MODE_PRESS, press_ticks($urandom_range(0, 1) ? SYM_DASH : SYM_DOT));
    end else begin
      send_item(MODE_GAP, long_gap());
      send_item(MODE_GAP, long_gap());
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_DOT_MIN:   cur_dot_min  = data[MS_W-1:0];
      REG_SPLIT:     cur_split    = data[MS_W-1:0];
      REG_DASH_MAX:  cur_dash_max = data[MS_W-1:0];
      REG_GAP_TICKS: cur_gap      = data[TICKS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_settings(int unsigned d_min, int unsigned d_split,
                               int unsigned d_max, int unsigned d_gap);
    write_reg(REG_DOT_MIN, 16'(d_min));
    write_reg(REG_SPLIT, 16'(d_split));
    write_reg(REG_DASH_MAX, 16'(d_max));
    write_reg(REG_GAP_TICKS, 16'(d_gap));
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int unsigned bound_ms [7];
    int unsigned lo, mid, hi, budget, target;
    bound_ms = '{30, 31, 200, 199, 201, 400, 399};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        settle();
        case (phase)
          1: load_settings(DOT_MIN_RST, SPLIT_RST, DASH_MAX_RST, GAP_TICKS_RST);
          2: load_settings(0, 8191, 8191, 0);
          3: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          4: load_settings(0, 1, MS_CEIL, 1);
          5: load_settings(400, 200, 30, 1000);
          default: begin
            lo  = $urandom_range(0, 120);
            mid = lo + $urandom_range(2, 400);
            hi  = mid + $urandom_range(2, 2000);
            load_settings(lo, mid, hi, $urandom_range(0, 40000));
          end
        endcase
      end
      if (phase == 1 || phase == 6) hold_req = 1'b1;
      if (phase == 0) begin
        // empty pattern at a gap, then a gap while disarmed
        send_item(MODE_GAP, 16'hFFFF);
        send_item(MODE_GAP, 16'hFFFF);
        send_item(MODE_PRESS, 16'd0);
        send_item(MODE_PRESS, 16'hFFFF);
        foreach (bound_ms[i]) send_item(MODE_PRESS, 16'(ms_ticks(bound_ms[i])));
        send_item(MODE_GAP, 16'd15625);
        send_item(MODE_GAP, 16'd15626);
        repeat (6) send_item(MODE_PRESS, 16'(ms_ticks(100)));
        send_item(MODE_GAP, 16'hFFFF);
        send_item(MODE_PRESS, 16'(ms_ticks(300)));
        send_item(MODE_PRESS, 16'(ms_ticks(300)));
        send_item(MODE_PRESS, 16'(ms_ticks(100)));
        send_item(MODE_GAP, 16'd15626);
      end
      budget = (phase == 3) ? 40 : (phase == 5) ? 60 : 300;
      target = sent + budget;
      while (sent < target) send_word();
    end
    settle();
    repeat (4) @(posedge clk);

    $display("Sent %0d key events across %0d register settings, with two long output holds.",
             sent, PHASES);
    $display("Checked %0d results: %0d characters, %0d unknown or overflowed patterns.",
             checked_count, char_count, unknown_count);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: sim.f
sv/mkd_pkg.sv
sv/mkd_sym_class.sv
sv/mkd_char_lookup.sv
sv/morse_key_decoder.sv
sv/mkd_checker.sv
tb/sv/morse_decode_checker.sv
tb/sv/testbench.sv
